FILE: rtl/core/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the nearest palette color search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int IDX_W  = 8;
  localparam int COMP_W = 8;
  localparam int SQ_W   = 2 * COMP_W;
  localparam int DIST_W = 18;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  // Travels with each palette read down the scan pipeline
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage : nps_pkg

`default_nettype wire

FILE: rtl/core/nps_palette_mem.sv
// ----------------------------------------------------------------------------
// nps_palette_mem
// Palette storage: one write port, one registered read port, and a valid bit
// per entry so that entries never written read as black after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_palette_mem #(
  parameter int ENTRIES = 256,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                wr_en,
  input  wire  [AW-1:0]      wr_addr,
  input  nps_pkg::rgb_t      wr_data,
  input  wire                rd_en,
  input  wire  [AW-1:0]      rd_addr,
  output nps_pkg::rgb_t      rd_data
);
  import nps_pkg::*;

  rgb_t               mem [ENTRIES];
  rgb_t               rdata_r;
  logic [ENTRIES-1:0] valid_r;
  logic               rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule : nps_palette_mem

`default_nettype wire

FILE: rtl/core/nps_dist.sv
// ----------------------------------------------------------------------------
// nps_dist
// Per-component squared difference between the query color and one palette
// entry, registered together with its scan tag.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist (
  input  wire                    clk,
  input  wire                    rst_n,
  input  nps_pkg::scan_tag_t     tag_in,
  input  nps_pkg::rgb_t          color,
  input  nps_pkg::rgb_t          entry,
  output nps_pkg::scan_tag_t     tag_out,
  output logic [nps_pkg::SQ_W-1:0] sq_red,
  output logic [nps_pkg::SQ_W-1:0] sq_green,
  output logic [nps_pkg::SQ_W-1:0] sq_blue
);
  import nps_pkg::*;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [COMP_W-1:0] d_red, d_green, d_blue;
  scan_tag_t         tag_r;
  logic [SQ_W-1:0]   sq_red_r, sq_green_r, sq_blue_r;

  assign d_red   = abs_diff(color.red,   entry.red);
  assign d_green = abs_diff(color.green, entry.green);
  assign d_blue  = abs_diff(color.blue,  entry.blue);

  always_ff @(posedge clk) begin
    sq_red_r   <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green_r <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue_r  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign tag_out  = tag_r;
  assign sq_red   = sq_red_r;
  assign sq_green = sq_green_r;
  assign sq_blue  = sq_blue_r;

endmodule : nps_dist

`default_nettype wire

FILE: rtl/core/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette of RGB entries with a nearest-color query by squared Euclidean
// distance, lowest index on ties, optional exclusion of reserved entries.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------
//   input     start / busy       in_cmd, in_entry_index, in_red, in_green,
//                                in_blue, in_skip_reserved
//   result    out_valid strobe   out_nearest_index, out_best_distance
//
// A write word keeps busy low. A query reads one palette entry per cycle
// from the memory port and holds busy until the last of its N entries has
// left the compare stage, N being the number of entries searched (ENTRIES,
// or the reserved-free range); the result strobes in the same cycle that
// busy falls. A query over an empty range strobes index 0, distance 0 in
// the next cycle. Reset clears the palette to black at once through
// per-entry valid bits. The result port has no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search #(
  parameter int ENTRIES      = 256,
  parameter int RESERVED_LOW = 10,
  parameter int RESERVED_END = 246
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_cmd,
  input  wire  [nps_pkg::IDX_W-1:0]    in_entry_index,
  input  wire  [nps_pkg::COMP_W-1:0]   in_red,
  input  wire  [nps_pkg::COMP_W-1:0]   in_green,
  input  wire  [nps_pkg::COMP_W-1:0]   in_blue,
  input  wire                          in_skip_reserved,
  output logic                         out_valid,
  output logic [nps_pkg::IDX_W-1:0]    out_nearest_index,
  output logic [nps_pkg::DIST_W-1:0]   out_best_distance
);
  import nps_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SKIP_END_INT = (RESERVED_END > ENTRIES) ? ENTRIES : RESERVED_END;
  localparam bit SKIP_EMPTY   = (RESERVED_LOW >= SKIP_END_INT);
  localparam logic [CW-1:0] FULL_END  = CW'(ENTRIES);
  localparam logic [CW-1:0] SKIP_END  = CW'(SKIP_END_INT);
  localparam logic [CW-1:0] SKIP_LOW  = CW'(RESERVED_LOW);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic [CW-1:0]     addr_inc;
  rgb_t              col_r, col_nxt;
  scan_tag_t         s1_tag_r, s1_tag_nxt;
  scan_tag_t         s2_tag;
  logic              first_r, first_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;

  logic              accept;
  logic              wr_en;
  logic              rd_en;
  rgb_t              wr_data;
  rgb_t              rd_data;
  logic [SQ_W-1:0]   sq_red, sq_green, sq_blue;
  logic [DIST_W-1:0] dist_sum;
  logic              take;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign wr_en   = accept && (in_cmd == CMD_WRITE)
                   && ({1'b0, in_entry_index} < (IDX_W + 1)'(ENTRIES));
  assign wr_data = '{red: in_red, green: in_green, blue: in_blue};
  assign rd_en   = (state_r == ST_SCAN);
  assign addr_inc = addr_r + CW'(1);

  nps_palette_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  nps_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (s1_tag_r),
    .color    (col_r),
    .entry    (rd_data),
    .tag_out  (s2_tag),
    .sq_red   (sq_red),
    .sq_green (sq_green),
    .sq_blue  (sq_blue)
  );

  assign dist_sum = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  // Only a strictly smaller distance replaces the best, so the lowest index wins ties
  assign take     = s2_tag.vld && (first_r || (dist_sum < best_dist_r));

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    col_nxt       = col_r;
    first_nxt     = first_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;

    s1_tag_nxt.vld  = rd_en;
    s1_tag_nxt.last = rd_en && (addr_inc == end_r);
    s1_tag_nxt.idx  = IDX_W'(addr_r);

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_QUERY)) begin
          col_nxt   = '{red: in_red, green: in_green, blue: in_blue};
          first_nxt = 1'b1;
          if (in_skip_reserved) begin
            if (SKIP_EMPTY) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = '0;
              out_dist_nxt  = '0;
            end else begin
              addr_nxt  = SKIP_LOW;
              end_nxt   = SKIP_END;
              state_nxt = ST_SCAN;
            end
          end else begin
            addr_nxt  = '0;
            end_nxt   = FULL_END;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_inc;
        if (addr_inc == end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last entry leaves the compare stage
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (s2_tag.vld) begin
      first_nxt = 1'b0;
    end
    if (take) begin
      best_idx_nxt  = s2_tag.idx;
      best_dist_nxt = dist_sum;
    end
    if (s2_tag.vld && s2_tag.last) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = best_idx_nxt;
      out_dist_nxt  = best_dist_nxt;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      s1_tag_r.vld <= 1'b0;
      out_valid_r  <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_tag_r     <= s1_tag_nxt;
      out_valid_r  <= out_valid_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r        <= addr_nxt;
    end_r         <= end_nxt;
    col_r         <= col_nxt;
    best_idx_r    <= best_idx_nxt;
    best_dist_r   <= best_dist_nxt;
    out_idx_r     <= out_idx_nxt;
    out_dist_r    <= out_dist_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;
  assign out_best_distance = out_dist_r;

endmodule : nearest_palette_color_search

`default_nettype wire
